// File: hdl/ast_pkg.sv
// ----------------------------------------------------------------------------
// ast_pkg
// Shared types and constants of the assembly source tokenizer.
// ----------------------------------------------------------------------------
package ast_pkg;

    localparam int POS_BITS  = 20;
    localparam int LINE_BITS = 16;

    localparam logic [3:0] K_IDENT  = 4'd0;
    localparam logic [3:0] K_LABEL  = 4'd1;
    localparam logic [3:0] K_INT    = 4'd2;
    localparam logic [3:0] K_FLOAT  = 4'd3;
    localparam logic [3:0] K_STRING = 4'd4;
    localparam logic [3:0] K_DIR0   = 4'd5;
    localparam logic [3:0] K_DEBUG  = 4'd11;
    localparam logic [3:0] K_ANNOT  = 4'd12;
    localparam logic [3:0] K_UNK    = 4'd13;
    localparam logic [3:0] K_EOF    = 4'd14;

    localparam logic [3:0] MD_IDLE    = 4'd0;
    localparam logic [3:0] MD_IDENT   = 4'd1;
    localparam logic [3:0] MD_WORD    = 4'd2;
    localparam logic [3:0] MD_ZERO    = 4'd3;
    localparam logic [3:0] MD_HEX     = 4'd4;
    localparam logic [3:0] MD_DEC     = 4'd5;
    localparam logic [3:0] MD_FRAC    = 4'd6;
    localparam logic [3:0] MD_MINUS   = 4'd7;
    localparam logic [3:0] MD_STRD    = 4'd8;
    localparam logic [3:0] MD_STRS    = 4'd9;
    localparam logic [3:0] MD_HASH    = 4'd10;
    localparam logic [3:0] MD_COMMENT = 4'd11;
    localparam logic [3:0] MD_DBGSKIP = 4'd12;
    localparam logic [3:0] MD_DBG     = 4'd13;
    localparam logic [3:0] MD_ANNSKIP = 4'd14;
    localparam logic [3:0] MD_ANN     = 4'd15;

    localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};
    localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};

    typedef struct packed {
        logic       kind;
        logic [7:0] source_byte;
    } t_in;

    typedef struct packed {
        logic [3:0]  token_kind;
        logic [19:0] start_offset;
        logic [19:0] token_length;
        logic [15:0] line_number;
        logic [19:0] column_number;
        logic        capital_first;
        logic        last_of_run;
    } t_out;

    function automatic logic is_digit(input logic [7:0] b);
        return b >= 8'h30 && b <= 8'h39;
    endfunction

    function automatic logic is_alpha(input logic [7:0] b);
        return (b >= 8'h61 && b <= 8'h7a) || (b >= 8'h41 && b <= 8'h5a) ||
               b == 8'h5f || b == 8'h40;
    endfunction

    function automatic logic is_ident(input logic [7:0] b);
        return is_alpha(b) || is_digit(b) || b == 8'h2f || b == 8'h2d || b == 8'h2e;
    endfunction

    function automatic logic is_hex(input logic [7:0] b);
        logic [7:0] l;
        l = b | 8'h20;
        return is_digit(b) || (l >= 8'h61 && l <= 8'h66);
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        return b == 8'h20 || b == 8'h09 || b == 8'h0d;
    endfunction

    // directive character at index i (0 when beyond the name)
    function automatic logic [7:0] dir_char(input logic [2:0] k, input logic [3:0] i);
        logic [87:0] s;
        logic [3:0]  n;
        case (k)
            3'd0: begin s = {".func", 48'h0}; n = 4'd5; end
            3'd1: begin s = {".const", 40'h0}; n = 4'd6; end
            3'd2: begin s = {".endfunc", 24'h0}; n = 4'd8; end
            3'd3: begin s = {".upvalue", 24'h0}; n = 4'd8; end
            3'd4: begin s = {".upvalues", 16'h0}; n = 4'd9; end
            default: begin s = {".registers", 8'h0}; n = 4'd10; end
        endcase
        if (i >= n) return 8'h00;
        return s[87 - 8*i -: 8];
    endfunction

    function automatic logic [3:0] dir_len(input logic [2:0] k);
        case (k)
            3'd0: return 4'd5;
            3'd1: return 4'd6;
            3'd2: return 4'd8;
            3'd3: return 4'd8;
            3'd4: return 4'd9;
            default: return 4'd10;
        endcase
    endfunction

endpackage

// File: hdl/ast_scan.sv
// ----------------------------------------------------------------------------
// ast_scan
// Per-byte scan logic: next scanner state and up to two tokens.
// ----------------------------------------------------------------------------
module ast_scan (
    input  ast_pkg::t_in                        i_item,
    input  logic [3:0]                          i_mode,
    input  logic [ast_pkg::POS_BITS-1:0]        i_pos,
    input  logic [ast_pkg::LINE_BITS-1:0]       i_line,
    input  logic [ast_pkg::POS_BITS-1:0]        i_lstart,
    input  logic [ast_pkg::POS_BITS-1:0]        i_tstart,
    input  logic [5:0]                          i_mask,
    input  logic [1:0]                          i_flags,
    output logic [3:0]                          o_mode,
    output logic [ast_pkg::POS_BITS-1:0]        o_pos,
    output logic [ast_pkg::LINE_BITS-1:0]       o_line,
    output logic [ast_pkg::POS_BITS-1:0]        o_lstart,
    output logic [ast_pkg::POS_BITS-1:0]        o_tstart,
    output logic [5:0]                          o_mask,
    output logic [1:0]                          o_flags,
    output logic [1:0]                          o_count,
    output ast_pkg::t_out                       o_tok0,
    output ast_pkg::t_out                       o_tok1
);
    import ast_pkg::*;

    logic [7:0]          b;
    logic [POS_BITS-1:0] p, pinc, s, wlen;
    logic                again, idle_pass;
    logic [3:0]          k1;
    logic [1:0]          cnt;
    t_out                tk [2];

    function automatic logic [19:0] fit(input logic [POS_BITS-1:0] v);
        return (POS_BITS > 20 && v > POS_BITS'(20'hFFFFF)) ? 20'hFFFFF : 20'(v);
    endfunction

    function automatic t_out mk(input logic [3:0] kd, input logic [POS_BITS-1:0] st,
                                input logic [POS_BITS-1:0] en, input logic cap,
                                input logic [LINE_BITS-1:0] ln,
                                input logic [POS_BITS-1:0] ls);
        t_out t;
        logic [POS_BITS-1:0] len, col;
        len = (en >= st) ? en - st : '0;
        col = (st >= ls) ? st - ls : '0;
        t.token_kind    = kd;
        t.start_offset  = 20'(st);
        t.token_length  = (kd == K_UNK) ? 20'd1 : fit(len);
        t.line_number   = (LINE_BITS > 16 && ln > LINE_BITS'(16'hFFFF)) ? 16'hFFFF : 16'(ln);
        t.column_number = (kd == K_EOF) ? 20'd0 :
                          (fit(col) == 20'hFFFFF) ? 20'hFFFFF : fit(col) + 20'd1;
        t.capital_first = cap;
        t.last_of_run   = 1'b0;
        return t;
    endfunction

    function automatic logic [3:0] word_kind(input logic [5:0] m,
                                             input logic [POS_BITS-1:0] len);
        logic [3:0] kd;
        kd = K_IDENT;
        for (int k = 0; k < 6; k++)
            if (m[k] && len == POS_BITS'(dir_len(3'(k)))) kd = K_DIR0 + 4'(k);
        return kd;
    endfunction

    always_comb begin
        b        = i_item.source_byte;
        p        = i_pos;
        pinc     = (p == POS_MAX) ? POS_MAX : p + 1'b1;
        s        = i_tstart;
        wlen     = p - s;
        o_mode   = i_mode;
        o_pos    = i_pos;
        o_line   = i_line;
        o_lstart = i_lstart;
        o_tstart = i_tstart;
        o_mask   = i_mask;
        o_flags  = i_flags;
        cnt      = 2'd0;
        again    = 1'b0;
        idle_pass = 1'b0;
        k1       = K_IDENT;
        tk[0]    = '0;
        tk[1]    = '0;
        if (i_item.kind) begin
            cnt = 2'd0;
            case (i_mode)
                MD_IDENT: begin tk[0] = mk(K_IDENT, s, p, i_flags[0], i_line, i_lstart);
                    cnt = 2'd1; end
                MD_WORD: begin tk[0] = mk(word_kind(i_mask, wlen), s, p, 1'b0, i_line,
                    i_lstart); cnt = 2'd1; end
                MD_ZERO, MD_HEX, MD_DEC: begin
                    tk[0] = mk(K_INT, s, p, 1'b0, i_line, i_lstart); cnt = 2'd1; end
                MD_FRAC: begin tk[0] = mk(K_FLOAT, s, p, 1'b0, i_line, i_lstart);
                    cnt = 2'd1; end
                MD_MINUS: begin tk[0] = mk(K_IDENT, s, p, 1'b0, i_line, i_lstart);
                    cnt = 2'd1; end
                MD_STRD, MD_STRS: begin
                    tk[0] = mk(K_STRING, s, p, 1'b0, i_line, i_lstart); cnt = 2'd1; end
                MD_DBGSKIP: begin tk[0] = mk(K_DEBUG, p, p, 1'b0, i_line, i_lstart);
                    cnt = 2'd1; end
                MD_ANNSKIP: begin tk[0] = mk(K_ANNOT, p, p, 1'b0, i_line, i_lstart);
                    cnt = 2'd1; end
                MD_DBG: begin tk[0] = mk(K_DEBUG, s, p, 1'b0, i_line, i_lstart);
                    cnt = 2'd1; end
                MD_ANN: begin tk[0] = mk(K_ANNOT, s, p, 1'b0, i_line, i_lstart);
                    cnt = 2'd1; end
                default: cnt = 2'd0;
            endcase
            tk[cnt[0]] = mk(K_EOF, p, p, 1'b0, i_line, i_lstart);
            cnt      = cnt + 2'd1;
            o_mode   = MD_IDLE;
            o_flags  = 2'b00;
            o_mask   = 6'h3F;
        end else begin
            // first pass in the current mode
            case (i_mode)
                MD_IDENT: begin
                    if (!is_ident(b)) begin
                        o_mode = MD_IDLE;
                        if (b == 8'h3a) begin
                            tk[0] = mk(K_LABEL, s, p, 1'b0, i_line, i_lstart); cnt = 2'd1;
                        end else begin
                            tk[0] = mk(K_IDENT, s, p, i_flags[0], i_line, i_lstart);
                            cnt = 2'd1; again = 1'b1;
                        end
                    end
                end
                MD_WORD: begin
                    if (is_ident(b)) begin
                        for (int k = 0; k < 6; k++)
                            if (wlen >= POS_BITS'(dir_len(3'(k))) ||
                                dir_char(3'(k), wlen[3:0]) != b)
                                o_mask[k] = 1'b0;
                    end else begin
                        tk[0] = mk(word_kind(i_mask, wlen), s, p, 1'b0, i_line, i_lstart);
                        cnt = 2'd1; o_mode = MD_IDLE; again = 1'b1;
                    end
                end
                MD_ZERO: begin
                    if ((b | 8'h20) == 8'h78) o_mode = MD_HEX;
                    else if (is_digit(b)) o_mode = MD_DEC;
                    else if (b == 8'h2e) o_mode = MD_FRAC;
                    else begin
                        tk[0] = mk(K_INT, s, p, 1'b0, i_line, i_lstart);
                        cnt = 2'd1; o_mode = MD_IDLE; again = 1'b1;
                    end
                end
                MD_HEX: begin
                    if (!is_hex(b)) begin
                        tk[0] = mk(K_INT, s, p, 1'b0, i_line, i_lstart);
                        cnt = 2'd1; o_mode = MD_IDLE; again = 1'b1;
                    end
                end
                MD_DEC: begin
                    if (b == 8'h2e) o_mode = MD_FRAC;
                    else if (!is_digit(b)) begin
                        tk[0] = mk(K_INT, s, p, 1'b0, i_line, i_lstart);
                        cnt = 2'd1; o_mode = MD_IDLE; again = 1'b1;
                    end
                end
                MD_FRAC: begin
                    if (!is_digit(b)) begin
                        tk[0] = mk(K_FLOAT, s, p, 1'b0, i_line, i_lstart);
                        cnt = 2'd1; o_mode = MD_IDLE; again = 1'b1;
                    end
                end
                MD_MINUS: begin
                    if (is_digit(b)) o_mode = MD_DEC;
                    else if (is_ident(b)) begin
                        // word with empty mask absorbs the byte
                        o_mode = MD_WORD; o_mask = 6'h00;
                    end else begin
                        tk[0] = mk(K_IDENT, s, p, 1'b0, i_line, i_lstart);
                        cnt = 2'd1; o_mode = MD_IDLE; again = 1'b1; o_mask = 6'h00;
                    end
                end
                MD_STRD, MD_STRS: begin
                    if (i_flags[1]) o_flags[1] = 1'b0;
                    else if (b == ((i_mode == MD_STRD) ? 8'h22 : 8'h27)) begin
                        tk[0] = mk(K_STRING, s, pinc, 1'b0, i_line, i_lstart);
                        cnt = 2'd1; o_mode = MD_IDLE;
                    end else if (b == 8'h5c) o_flags[1] = 1'b1;
                end
                MD_HASH: begin
                    if (b == 8'h5e) o_mode = MD_DBGSKIP;
                    else if (b == 8'h40) o_mode = MD_ANNSKIP;
                    else if (b == 8'h0a) begin o_mode = MD_IDLE; again = 1'b1; end
                    else o_mode = MD_COMMENT;
                end
                MD_COMMENT: begin
                    if (b == 8'h0a) begin o_mode = MD_IDLE; again = 1'b1; end
                end
                MD_DBGSKIP, MD_ANNSKIP: begin
                    if (!is_space(b)) begin
                        o_tstart = p; o_flags = 2'b00;
                        if (i_mode == MD_DBGSKIP) begin
                            if (b == 8'h0a) begin
                                tk[0] = mk(K_DEBUG, p, p, 1'b0, i_line, i_lstart);
                                cnt = 2'd1; o_mode = MD_IDLE; again = 1'b1;
                            end else o_mode = MD_DBG;
                        end else begin
                            if (is_ident(b)) o_mode = MD_ANN;
                            else begin
                                tk[0] = mk(K_ANNOT, p, p, 1'b0, i_line, i_lstart);
                                cnt = 2'd1; o_mode = MD_IDLE; again = 1'b1;
                            end
                        end
                    end
                end
                MD_DBG: begin
                    if (b == 8'h0a) begin
                        tk[0] = mk(K_DEBUG, s, p, 1'b0, i_line, i_lstart);
                        cnt = 2'd1; o_mode = MD_IDLE; again = 1'b1;
                    end
                end
                MD_ANN: begin
                    if (!is_ident(b)) begin
                        tk[0] = mk(K_ANNOT, s, p, 1'b0, i_line, i_lstart);
                        cnt = 2'd1; o_mode = MD_IDLE; again = 1'b1;
                    end
                end
                default: idle_pass = 1'b1;
            endcase
            if (again) idle_pass = 1'b1;
            if (idle_pass) begin
                o_mode = MD_IDLE;
                if (is_space(b)) begin
                    o_mode = MD_IDLE;
                end else if (b == 8'h0a) begin
                    o_line   = (i_line == LINE_MAX) ? LINE_MAX : i_line + 1'b1;
                    o_lstart = pinc;
                end else if (is_alpha(b)) begin
                    o_tstart = p; o_mode = MD_IDENT;
                    o_flags = {1'b0, (b >= 8'h41 && b <= 8'h5a)};
                end else if (b == 8'h2e) begin
                    o_tstart = p; o_mode = MD_WORD; o_flags = 2'b00; o_mask = 6'h3F;
                end else if (is_digit(b)) begin
                    o_tstart = p; o_flags = 2'b00;
                    o_mode = (b == 8'h30) ? MD_ZERO : MD_DEC;
                end else if (b == 8'h2d) begin
                    o_tstart = p; o_mode = MD_MINUS; o_flags = 2'b00;
                end else if (b == 8'h22) begin
                    o_tstart = p; o_mode = MD_STRD; o_flags = 2'b00;
                end else if (b == 8'h27) begin
                    o_tstart = p; o_mode = MD_STRS; o_flags = 2'b00;
                end else if (b == 8'h23) begin
                    o_mode = MD_HASH;
                end else begin
                    k1 = K_UNK;
                    tk[cnt[0]] = mk(k1, p, p + 1'b1, 1'b0, i_line, i_lstart);
                    cnt = cnt + 2'd1;
                end
            end
            o_pos = pinc;
        end
        o_count = cnt;
        if (cnt == 2'd2) tk[1].last_of_run = 1'b1;
        else if (cnt == 2'd1) tk[0].last_of_run = 1'b1;
        o_tok0 = tk[0];
        o_tok1 = tk[1];
    end

endmodule

// File: hdl/assembly_source_tokenizer.sv
// ----------------------------------------------------------------------------
// assembly_source_tokenizer
// Streaming tokenizer for assembly source text.
// ----------------------------------------------------------------------------
// Input channel: i_in_valid / o_in_stall carry one source byte or an
// end-of-input marker per transaction. Output channel: o_out_valid /
// i_out_stall carry one token per transaction; last_of_run marks the final
// token caused by one input transaction (at most two per input).
// The scanner state and the first token of an accepted input are registered
// at acceptance; that token reaches the output in the cycle after, and a
// second one waits in the pending register. Throughput: one input per cycle
// when that input yields at most one token and the receiver does not stall;
// an input that yields two tokens holds the input side while the second is pending.
// A byte that causes no token produces nothing at the output.
// Reset clears the scan state and positions, and sets the line counter to
// one. While the receiver stalls, the output token holds and the input
// stalls whenever a token is held at the output or a second one is pending.
// i_cfg_we writes the first line number and loads the line counter; an input accepted in the same cycle takes priority.
// ----------------------------------------------------------------------------
module assembly_source_tokenizer (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic           i_cfg_wdata,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  ast_pkg::t_in   i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output ast_pkg::t_out  o_out_data
);
    import ast_pkg::*;

    logic [3:0]           r_mode, n_mode;
    logic [POS_BITS-1:0]  r_pos, n_pos, r_lstart, n_lstart, r_tstart, n_tstart;
    logic [LINE_BITS-1:0] r_line, n_line;
    logic [5:0]           r_mask, n_mask;
    logic [1:0]           r_flags, n_flags, cnt;
    t_out                 tok0, tok1;
    t_out                 r_out, r_pend;
    logic                 r_ov, r_pv;
    logic                 acc, out_free;

    ast_scan u_scan (
        .i_item  (i_in_data), .i_mode(r_mode), .i_pos(r_pos), .i_line(r_line),
        .i_lstart(r_lstart), .i_tstart(r_tstart), .i_mask(r_mask), .i_flags(r_flags),
        .o_mode  (n_mode), .o_pos(n_pos), .o_line(n_line), .o_lstart(n_lstart),
        .o_tstart(n_tstart), .o_mask(n_mask), .o_flags(n_flags), .o_count(cnt),
        .o_tok0  (tok0), .o_tok1(tok1)
    );

    // output register free after this edge
    assign out_free   = !r_ov || !i_out_stall;
    assign o_in_stall = r_pv || !out_free;
    assign acc        = i_in_valid && !o_in_stall;
    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MD_IDLE;
            r_pos    <= '0;
            r_line   <= LINE_BITS'(1);
            r_lstart <= '0;
            r_tstart <= '0;
            r_mask   <= 6'h3F;
            r_flags  <= 2'b00;
            r_ov     <= 1'b0;
            r_pv     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_line  <= LINE_BITS'(i_cfg_wdata);
            end
            if (acc) begin
                r_mode   <= n_mode;
                r_pos    <= n_pos;
                r_line   <= n_line;
                r_lstart <= n_lstart;
                r_tstart <= n_tstart;
                r_mask   <= n_mask;
                r_flags  <= n_flags;
            end
            if (out_free) begin
                if (r_pv) begin
                    r_out <= r_pend;
                    r_ov  <= 1'b1;
                    r_pv  <= 1'b0;
                end else if (acc && cnt != 2'd0) begin
                    r_out <= tok0;
                    r_ov  <= 1'b1;
                    if (cnt == 2'd2) begin
                        r_pend <= tok1;
                        r_pv   <= 1'b1;
                    end
                end else begin
                    r_ov <= 1'b0;
                end
            end
        end
    end

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && i_out_stall |=> r_ov && $stable(r_out))
        else $error("output token changed under stall");
    a_pend_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pv |-> o_in_stall)
        else $error("input taken with pending token");
    a_pend_second: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pv |-> r_ov && !r_out.last_of_run)
        else $error("pending token without first token");
    a_line_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !acc && !i_cfg_we |=> $stable(r_line))
        else $error("line count moved without input");

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the assembly source tokenizer: random source text
// built from well-formed token fragments plus noise bytes is streamed in with
// random gaps and output stalls, and every token is compared against an
// in-bench scanner model across several first-line-number settings.
// ----------------------------------------------------------------------------
module tb_top;
    import ast_pkg::*;

    logic  i_clk = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  i_cfg_we = 1'b0;
    logic  i_cfg_wdata = 1'b0;
    logic  i_in_valid = 1'b0;
    logic  o_in_stall;
    t_in   i_in_data = '0;
    logic  o_out_valid;
    logic  i_out_stall = 1'b0;
    t_out  o_out_data;

    assembly_source_tokenizer dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data)
    );

    always #2 i_clk = ~i_clk;

    // ---------------- scanner model ----------------
    logic [3:0]  scan_md = MD_IDLE;
    logic [19:0] byte_pos = '0, line_begin = '0, tok_begin = '0;
    logic [15:0] line_cnt = 16'd1;
    logic [5:0]  dir_mask = 6'h3f;
    logic        cap_flag = 1'b0, esc_flag = 1'b0;
    int          tok_cnt;
    t_out        token_q[$];
    string       dir_names[6] = '{".func", ".const", ".endfunc", ".upvalue", ".upvalues",
                                  ".registers"};

    function automatic bit c_digit(logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction
    function automatic bit c_alpha(logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_" || b == "@";
    endfunction
    function automatic bit c_word(logic [7:0] b);
        return c_alpha(b) || c_digit(b) || b == "/" || b == "-" || b == ".";
    endfunction
    function automatic bit c_hex(logic [7:0] b);
        return c_digit(b) || ((b | 8'h20) >= "a" && (b | 8'h20) <= "f");
    endfunction
    function automatic bit c_blank(logic [7:0] b);
        return b == " " || b == 8'h09 || b == 8'h0d;
    endfunction
    function automatic logic [19:0] pos_next(logic [19:0] p);
        return (p == POS_MAX) ? p : p + 20'd1;
    endfunction

    function void push_token(logic [3:0] k, logic [19:0] s, logic [19:0] e, logic cap);
        t_out t;
        logic [20:0] col;
        if (tok_cnt >= 2) return;
        col = (s >= line_begin) ? {1'b0, s} - {1'b0, line_begin} + 21'd1 : 21'd1;
        t.token_kind = k;
        t.start_offset = s;
        t.token_length = (k == K_UNK) ? 20'd1 : ((e >= s) ? e - s : 20'd0);
        t.line_number = line_cnt;
        t.column_number = (k == K_EOF) ? 20'd0 : (col[20] ? POS_MAX : col[19:0]);
        t.capital_first = cap;
        t.last_of_run = 1'b0;
        token_q.push_back(t);
        tok_cnt++;
    endfunction

    function void close_dot_word(logic [19:0] e);
        logic [3:0] k;
        k = K_IDENT;
        for (int i = 0; i < 6; i++)
            if (dir_mask[i] && (e - tok_begin) == dir_names[i].len()) k = K_DIR0 + 4'(i);
        push_token(k, tok_begin, e, 1'b0);
    endfunction

    function void open_token(logic [19:0] p, logic [3:0] m);
        tok_begin = p;
        cap_flag = 1'b0;
        esc_flag = 1'b0;
        scan_md = m;
    endfunction

    function bit scan_byte(logic [7:0] b, logic [19:0] p);
        logic [19:0] s;
        int          idx;
        s = tok_begin;
        case (scan_md)
            MD_IDENT: begin
                if (c_word(b)) return 1;
                scan_md = MD_IDLE;
                if (b == ":") begin
                    push_token(K_LABEL, s, p, 1'b0);
                    return 1;
                end
                push_token(K_IDENT, s, p, cap_flag);
                return 0;
            end
            MD_WORD: begin
                if (c_word(b)) begin
                    idx = p - s;
                    for (int k = 0; k < 6; k++)
                        if (idx >= dir_names[k].len() || dir_names[k][idx] != b)
                            dir_mask[k] = 1'b0;
                    return 1;
                end
                close_dot_word(p);
                scan_md = MD_IDLE;
                return 0;
            end
            MD_ZERO: begin
                if ((b | 8'h20) == "x") begin
                    scan_md = MD_HEX;
                    return 1;
                end
                scan_md = MD_DEC;
                return 0;
            end
            MD_HEX: begin
                if (c_hex(b)) return 1;
                push_token(K_INT, s, p, 1'b0);
                scan_md = MD_IDLE;
                return 0;
            end
            MD_DEC: begin
                if (c_digit(b)) return 1;
                if (b == ".") begin
                    scan_md = MD_FRAC;
                    return 1;
                end
                push_token(K_INT, s, p, 1'b0);
                scan_md = MD_IDLE;
                return 0;
            end
            MD_FRAC: begin
                if (c_digit(b)) return 1;
                push_token(K_FLOAT, s, p, 1'b0);
                scan_md = MD_IDLE;
                return 0;
            end
            MD_MINUS: begin
                if (c_digit(b)) begin
                    scan_md = MD_DEC;
                    return 1;
                end
                dir_mask = '0;
                scan_md = MD_WORD;
                return 0;
            end
            MD_STRD, MD_STRS: begin
                if (esc_flag) begin
                    esc_flag = 1'b0;
                    return 1;
                end
                if (b == ((scan_md == MD_STRD) ? 8'h22 : 8'h27)) begin
                    push_token(K_STRING, s, pos_next(p), 1'b0);
                    scan_md = MD_IDLE;
                    return 1;
                end
                if (b == 8'h5c) esc_flag = 1'b1;
                return 1;
            end
            MD_HASH: begin
                if (b == "^") begin
                    scan_md = MD_DBGSKIP;
                    return 1;
                end
                if (b == "@") begin
                    scan_md = MD_ANNSKIP;
                    return 1;
                end
                scan_md = MD_COMMENT;
                return 0;
            end
            MD_COMMENT: begin
                if (b == 8'h0a) begin
                    scan_md = MD_IDLE;
                    return 0;
                end
                return 1;
            end
            MD_DBGSKIP, MD_ANNSKIP: begin
                if (c_blank(b)) return 1;
                open_token(p, (scan_md == MD_DBGSKIP) ? MD_DBG : MD_ANN);
                return 0;
            end
            MD_DBG: begin
                if (b != 8'h0a) return 1;
                push_token(K_DEBUG, s, p, 1'b0);
                scan_md = MD_IDLE;
                return 0;
            end
            MD_ANN: begin
                if (c_word(b)) return 1;
                push_token(K_ANNOT, s, p, 1'b0);
                scan_md = MD_IDLE;
                return 0;
            end
            default: ;
        endcase
        scan_md = MD_IDLE;
        if (c_blank(b)) return 1;
        if (b == 8'h0a) begin
            if (line_cnt != LINE_MAX) line_cnt++;
            line_begin = pos_next(p);
            return 1;
        end
        if (c_alpha(b)) begin
            open_token(p, MD_IDENT);
            cap_flag = (b >= "A" && b <= "Z");
            return 1;
        end
        if (b == ".") begin
            open_token(p, MD_WORD);
            dir_mask = 6'h3f;
            return 1;
        end
        if (c_digit(b)) begin
            open_token(p, (b == "0") ? MD_ZERO : MD_DEC);
            return 1;
        end
        if (b == "-") begin
            open_token(p, MD_MINUS);
            return 1;
        end
        if (b == 8'h22) begin
            open_token(p, MD_STRD);
            return 1;
        end
        if (b == 8'h27) begin
            open_token(p, MD_STRS);
            return 1;
        end
        if (b == "#") begin
            scan_md = MD_HASH;
            return 1;
        end
        push_token(K_UNK, p, p + 20'd1, 1'b0);
        return 1;
    endfunction

    function void close_input(logic [19:0] p);
        logic [19:0] s;
        s = tok_begin;
        case (scan_md)
            MD_IDENT: push_token(K_IDENT, s, p, cap_flag);
            MD_WORD: close_dot_word(p);
            MD_ZERO, MD_HEX, MD_DEC: push_token(K_INT, s, p, 1'b0);
            MD_FRAC: push_token(K_FLOAT, s, p, 1'b0);
            MD_MINUS: push_token(K_IDENT, s, p, 1'b0);
            MD_STRD, MD_STRS: push_token(K_STRING, s, p, 1'b0);
            MD_DBGSKIP: push_token(K_DEBUG, p, p, 1'b0);
            MD_ANNSKIP: push_token(K_ANNOT, p, p, 1'b0);
            MD_DBG: push_token(K_DEBUG, s, p, 1'b0);
            MD_ANN: push_token(K_ANNOT, s, p, 1'b0);
            default: ;
        endcase
        push_token(K_EOF, p, p, 1'b0);
        scan_md = MD_IDLE;
        cap_flag = 1'b0;
        esc_flag = 1'b0;
        dir_mask = 6'h3f;
    endfunction

    function void predict_tokens(t_in it);
        tok_cnt = 0;
        if (it.kind) begin
            close_input(byte_pos);
        end else begin
            for (int n = 0; n < 6; n++)
                if (scan_byte(it.source_byte, byte_pos)) break;
            byte_pos = pos_next(byte_pos);
        end
        if (tok_cnt > 0) token_q[$].last_of_run = 1'b1;
    endfunction

    // ---------------- stimulus ----------------
    t_in   source_q[$];
    int    err_cnt = 0;
    bit    calm = 0;

    task automatic put_byte(logic [7:0] b);
        source_q.push_back('{kind: 1'b0, source_byte: b});
    endtask

    task automatic put_text(string s);
        for (int i = 0; i < s.len(); i++) put_byte(s[i]);
    endtask

    task automatic put_eof();
        source_q.push_back('{kind: 1'b1, source_byte: 8'($urandom)});
    endtask

    function automatic logic [7:0] any_letter();
        case ($urandom_range(0, 3))
            0: return 8'("A" + $urandom_range(0, 25));
            1: return $urandom_range(0, 1) ? "_" : "@";
            default: return 8'("a" + $urandom_range(0, 25));
        endcase
    endfunction

    function automatic logic [7:0] any_word_char();
        case ($urandom_range(0, 5))
            0: return 8'("0" + $urandom_range(0, 9));
            1: return $urandom_range(0, 1) ? "-" : ($urandom_range(0, 1) ? "/" : ".");
            default: return any_letter();
        endcase
    endfunction

    task automatic put_digits(int lo, int hi);
        repeat ($urandom_range(lo, hi)) put_byte(8'("0" + $urandom_range(0, 9)));
    endtask

    task automatic put_fragment();
        string d;
        case ($urandom_range(0, 15))
            0, 1: begin
                put_byte(any_letter());
                repeat ($urandom_range(0, 6)) put_byte(any_word_char());
                if ($urandom_range(0, 2) == 0) put_byte(":");
            end
            2, 3: begin
                d = dir_names[$urandom_range(0, 5)];
                if ($urandom_range(0, 3) == 0) d = d.substr(0, $urandom_range(0, d.len() - 1));
                put_text(d);
                if ($urandom_range(0, 3) == 0) put_byte(any_word_char());
            end
            4: begin
                put_byte(".");
                repeat ($urandom_range(0, 5)) put_byte(any_word_char());
            end
            5, 6: begin
                if ($urandom_range(0, 2) == 0) put_byte("-");
                put_digits(1, 4);
                if ($urandom_range(0, 1)) begin
                    put_byte(".");
                    put_digits(0, 3);
                end
            end
            7: begin
                if ($urandom_range(0, 3) == 0) put_byte("-");
                put_byte("0");
                put_byte($urandom_range(0, 1) ? "x" : "X");
                repeat ($urandom_range(0, 5))
                    put_byte($urandom_range(0, 1) ? 8'("0" + $urandom_range(0, 9))
                                                  : 8'("a" + $urandom_range(0, 7)));
            end
            8: begin
                put_byte("-");
                repeat ($urandom_range(0, 3)) put_byte(any_word_char());
            end
            9, 10: begin
                d = $urandom_range(0, 1) ? "\"" : "'";
                put_text(d);
                repeat ($urandom_range(0, 8))
                    case ($urandom_range(0, 5))
                        0: put_byte(8'h5c);
                        1: put_byte($urandom_range(0, 1) ? 8'h22 : 8'h27);
                        2: put_byte(8'($urandom));
                        default: put_byte(8'($urandom_range(32, 126)));
                    endcase
                if ($urandom_range(0, 6) != 0) put_text(d);
            end
            11: begin
                put_text("#^");
                repeat ($urandom_range(0, 2)) put_byte(" ");
                repeat ($urandom_range(0, 8)) put_byte(8'($urandom_range(32, 126)));
                put_byte(8'h0a);
            end
            12: begin
                put_text("#@");
                repeat ($urandom_range(0, 2)) put_byte(8'h09);
                repeat ($urandom_range(0, 5)) put_byte(any_word_char());
            end
            13: begin
                put_byte("#");
                repeat ($urandom_range(0, 6)) put_byte(8'($urandom_range(32, 126)));
                put_byte(8'h0a);
            end
            default: put_byte(8'($urandom));
        endcase
        case ($urandom_range(0, 7))
            0: put_byte(8'h0a);
            1: put_byte(8'h09);
            2: put_byte(8'h0d);
            3, 4: put_byte(" ");
            default: ;
        endcase
        if ($urandom_range(0, 30) == 0) put_eof();
    endtask

    function automatic int pick_gap();
        int r;
        if ($urandom_range(0, 199) == 0) calm = ~calm;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // ---------------- driver / monitor ----------------
    bit in_took = 0;
    int in_gap = 0, stall_gap = 0, quiet_cycles = 0;

    task automatic report_err(string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        err_cnt++;
    endtask

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !in_took) begin
                // hold the stalled transaction
            end else if (in_gap > 0) begin
                i_in_valid <= 1'b0;
                in_gap--;
            end else if (source_q.size() > 0) begin
                i_in_data <= source_q.pop_front();
                i_in_valid <= 1'b1;
                in_gap = pick_gap();
            end else begin
                i_in_valid <= 1'b0;
            end
            if (stall_gap > 0) begin
                i_out_stall <= 1'b1;
                stall_gap--;
            end else begin
                i_out_stall <= 1'b0;
                stall_gap = pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        t_out want;
        in_took = i_rst_n && i_in_valid && !o_in_stall;
        if (i_rst_n && i_cfg_we) line_cnt = {15'd0, i_cfg_wdata};
        if (in_took) predict_tokens(i_in_data);
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (token_q.size() == 0) begin
                report_err("token with no expectation pending");
            end else begin
                want = token_q.pop_front();
                if (o_out_data.token_kind !== want.token_kind)
                    report_err($sformatf("token_kind %0d exp %0d",
                        o_out_data.token_kind, want.token_kind));
                if (o_out_data.start_offset !== want.start_offset)
                    report_err($sformatf("start_offset %0d exp %0d",
                        o_out_data.start_offset, want.start_offset));
                if (o_out_data.token_length !== want.token_length)
                    report_err($sformatf("token_length %0d exp %0d",
                        o_out_data.token_length, want.token_length));
                if (o_out_data.line_number !== want.line_number)
                    report_err($sformatf("line_number %0d exp %0d",
                        o_out_data.line_number, want.line_number));
                if (o_out_data.column_number !== want.column_number)
                    report_err($sformatf("column_number %0d exp %0d",
                        o_out_data.column_number, want.column_number));
                if (o_out_data.capital_first !== want.capital_first)
                    report_err($sformatf("capital_first %0b exp %0b",
                        o_out_data.capital_first, want.capital_first));
                if (o_out_data.last_of_run !== want.last_of_run)
                    report_err($sformatf("last_of_run %0b exp %0b",
                        o_out_data.last_of_run, want.last_of_run));
            end
            quiet_cycles = 0;
        end else if (in_took || i_cfg_we || !i_rst_n ||
                     (source_q.size() == 0 && !i_in_valid && token_q.size() == 0)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= 5000) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    task automatic wait_drained();
        do @(posedge i_clk);
        while (source_q.size() != 0 || i_in_valid || token_q.size() != 0);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_first_line(logic v);
        @(negedge i_clk);
        i_cfg_wdata <= v;
        i_cfg_we <= 1'b1;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        logic cfg_plan[3];
        cfg_plan = '{1'b0, 1'b1, 1'b0};
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        put_text("Add: x_1 .func .upvalues .registers .cons 0x1F -7 -0x 3.25 -a9 ");
        put_text("'a\\'b'\n#^ dbg\n#@ note: \xff\x80 # c\n\"open\\");
        put_eof();
        put_text("#^");
        put_eof();
        put_text("#@");
        put_eof();
        while (source_q.size() < 200) put_fragment();
        put_eof();
        wait_drained();

        foreach (cfg_plan[i]) begin
            write_first_line(cfg_plan[i]);
            while (source_q.size() < 300) put_fragment();
            put_eof();
            wait_drained();
        end

        repeat (20) @(posedge i_clk);
        if (token_q.size() != 0) report_err("expected tokens never arrived");
        if (err_cnt == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule

// File: files.f
hdl/ast_pkg.sv
hdl/ast_scan.sv
hdl/assembly_source_tokenizer.sv
verif/tb_top.sv
